[rtl/core/smts_pkg.sv]
// Shared types and constants for the sorted multi-timer scheduler.
// No dependencies.
package smts_pkg;

	// Command codes
	localparam logic [3:0] CMD_TICK     = 4'd0;
	localparam logic [3:0] CMD_CREATE   = 4'd1;
	localparam logic [3:0] CMD_START    = 4'd2;
	localparam logic [3:0] CMD_STOP     = 4'd3;
	localparam logic [3:0] CMD_DELETE   = 4'd4;
	localparam logic [3:0] CMD_SET_INTV = 4'd5;
	localparam logic [3:0] CMD_ONESHOT  = 4'd6;
	localparam logic [3:0] CMD_PERIODIC = 4'd7;
	localparam logic [3:0] CMD_READ     = 4'd8;

	// Result kinds
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Most timers reported by one tick
	localparam int unsigned MAX_FIRE = 16;
	localparam int unsigned FIRE_W   = 5;

	// Operation broadcast to every queue cell
	typedef enum logic [1:0] {
		Q_NONE,
		Q_INSERT,
		Q_REMOVE
	} q_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CALC,
		S_INS,
		S_RESP,
		S_DRAIN
	} state_t;

endpackage

[rtl/core/smts_if.sv]
// Handshake channels for commands and results of the timer scheduler.
// No dependencies.
interface smts_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [3:0]  timer_id;
	logic [31:0] value;
	logic        periodic;

	modport source (output valid, command, timer_id, value, periodic, input ready);
	modport sink   (input valid, command, timer_id, value, periodic, output ready);
endinterface

interface smts_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  fired_id;
	logic [31:0] read_value;
	logic        last;

	modport source (output valid, kind, fired_id, read_value, last, input ready);
	modport sink   (input valid, kind, fired_id, read_value, last, output ready);
endinterface

[rtl/core/sorted_multi_timer_scheduler.sv]
// Sorted multi-timer scheduler: slot tables, sequencer and result register.
// Start-type commands add a deadline add and a queue insert after the command decode.
// A tick pops due timers from the head of the cell chain, one entry per cycle while the
// result register is free, then computes a new deadline for and reinserts each periodic timer.
// One item in flight at a time; the result register frees the output side.
// Reset clears time, slot flags and queue cells; intervals are undefined until written.
module sorted_multi_timer_scheduler #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned TICK_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	smts_cmd_if.sink    cmd,
	smts_res_if.source  res
);

	localparam int unsigned SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned IDW    = (SLOT_W > 4) ? SLOT_W : 4;
	localparam int unsigned RA_W   = $clog2(smts_pkg::MAX_FIRE);

	smts_pkg::state_t state_q, state_d;

	// latched command
	logic [3:0]            cmd_q;
	logic [3:0]            tid_q;
	logic [31:0]           val_q;
	logic                  per_q;
	logic                  tick_q;

	// slot tables
	logic [NUM_TIMERS-1:0] alloc_q, run_q, mode_q;
	logic [31:0]           period_q [NUM_TIMERS];

	logic [TICK_BITS-1:0]  now_q;
	logic [SLOT_W-1:0]     sid_q;
	logic [TICK_BITS-1:0]  dl_q;

	// tick drain bookkeeping
	logic [smts_pkg::FIRE_W-1:0] fire_n_q, nre_q, rr_q;
	logic [SLOT_W-1:0]     rearm_q [smts_pkg::MAX_FIRE];
	logic                  pend_v_q;
	logic [SLOT_W-1:0]     pend_id_q;

	// pending response of a non-tick command
	logic [1:0]            rkind_q;
	logic [31:0]           rval_q;

	// result register
	logic                  out_v_q;
	logic [1:0]            out_kind_q;
	logic [3:0]            out_id_q;
	logic [31:0]           out_rv_q;
	logic                  out_last_q;

	// queue
	smts_pkg::q_op_t       q_op;
	logic [SLOT_W-1:0]     q_id;
	logic [TICK_BITS-1:0]  q_dl;
	logic                  head_valid;
	logic [SLOT_W-1:0]     head_id;
	logic [TICK_BITS-1:0]  head_dl;

	logic                  out_free;
	logic                  out_load;
	logic                  accept;
	logic [IDW-1:0]        id_ext;
	logic [SLOT_W-1:0]     slot;
	logic                  id_ok;
	logic [TICK_BITS-1:0]  head_diff;
	logic                  due;
	logic [SLOT_W-1:0]     calc_sid;

	assign out_free = !out_v_q || res.ready;
	assign accept   = cmd.valid && cmd.ready;
	assign id_ext   = IDW'(tid_q);
	assign slot     = id_ext[SLOT_W-1:0];
	assign id_ok    = {1'b0, id_ext} < (IDW+1)'(NUM_TIMERS);

	// head expiry under wrap compare
	assign head_diff = head_dl - now_q;
	assign due       = head_valid && (fire_n_q < smts_pkg::FIRE_W'(smts_pkg::MAX_FIRE)) &&
			((head_diff == '0) || head_diff[TICK_BITS-1]);
	assign calc_sid  = tick_q ? rearm_q[rr_q[RA_W-1:0]] : sid_q;

	assign cmd.ready      = (state_q == smts_pkg::S_IDLE);
	assign res.valid      = out_v_q;
	assign res.kind       = out_kind_q;
	assign res.fired_id   = out_id_q;
	assign res.read_value = out_rv_q;
	assign res.last       = out_last_q;

	smts_queue #(
		.NUM_CELLS (NUM_TIMERS),
		.SLOT_W    (SLOT_W),
		.TICK_BITS (TICK_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (q_op),
		.op_id      (q_id),
		.op_dl      (q_dl),
		.head_valid (head_valid),
		.head_id    (head_id),
		.head_dl    (head_dl)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= smts_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// next state, queue operation and result load
	always_comb begin
		state_d  = state_q;
		q_op     = smts_pkg::Q_NONE;
		q_id     = slot;
		q_dl     = dl_q;
		out_load = 1'b0;
		unique case (state_q)
			smts_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (cmd.command == smts_pkg::CMD_TICK) ?
						smts_pkg::S_DRAIN : smts_pkg::S_EXEC;
				end
			end
			smts_pkg::S_EXEC: begin
				state_d = smts_pkg::S_RESP;
				if (cmd_q <= smts_pkg::CMD_READ && id_ok) begin
					if (cmd_q == smts_pkg::CMD_CREATE) begin
						if (alloc_q[slot] && run_q[slot]) q_op = smts_pkg::Q_REMOVE;
					end else if (alloc_q[slot]) begin
						case (cmd_q)
							smts_pkg::CMD_START, smts_pkg::CMD_SET_INTV,
							smts_pkg::CMD_PERIODIC: begin
								q_op    = smts_pkg::Q_REMOVE;
								state_d = smts_pkg::S_CALC;
							end
							smts_pkg::CMD_STOP, smts_pkg::CMD_DELETE: q_op = smts_pkg::Q_REMOVE;
							default: ;
						endcase
					end
				end
			end
			smts_pkg::S_CALC: begin
				if (tick_q && rr_q == nre_q) state_d = smts_pkg::S_IDLE;
				else                         state_d = smts_pkg::S_INS;
			end
			smts_pkg::S_INS: begin
				q_op    = smts_pkg::Q_INSERT;
				q_id    = sid_q;
				state_d = tick_q ? smts_pkg::S_CALC : smts_pkg::S_RESP;
			end
			smts_pkg::S_RESP: begin
				if (out_free) begin
					state_d  = smts_pkg::S_IDLE;
					out_load = 1'b1;
				end
			end
			smts_pkg::S_DRAIN: begin
				if (due) begin
					if (!pend_v_q || out_free) begin
						q_op     = smts_pkg::Q_REMOVE;
						q_id     = head_id;
						out_load = pend_v_q;
					end
				end else if (out_free) begin
					state_d  = smts_pkg::S_CALC;
					out_load = 1'b1;
				end
			end
			default: state_d = smts_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			alloc_q  <= '0;
			run_q    <= '0;
			mode_q   <= '0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			tick_q   <= 1'b0;
			fire_n_q <= '0;
			nre_q    <= '0;
			rr_q     <= '0;
		end else begin
			// result valid: a new load wins over the drain
			if (out_load)       out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
			case (state_q)
				smts_pkg::S_IDLE: begin
					if (accept) begin
						tick_q   <= (cmd.command == smts_pkg::CMD_TICK);
						fire_n_q <= '0;
						nre_q    <= '0;
						rr_q     <= '0;
						pend_v_q <= 1'b0;
						if (cmd.command == smts_pkg::CMD_TICK) now_q <= now_q + 1'b1;
					end
				end
				smts_pkg::S_EXEC: begin
					if (cmd_q <= smts_pkg::CMD_READ && id_ok) begin
						if (cmd_q == smts_pkg::CMD_CREATE) begin
							if (alloc_q[slot] && run_q[slot]) begin
								run_q[slot] <= 1'b0;
							end else begin
								alloc_q[slot] <= 1'b1;
								run_q[slot]   <= 1'b0;
								mode_q[slot]  <= per_q;
							end
						end else if (alloc_q[slot]) begin
							case (cmd_q)
								smts_pkg::CMD_STOP:     run_q[slot] <= 1'b0;
								smts_pkg::CMD_DELETE: begin
									run_q[slot]   <= 1'b0;
									alloc_q[slot] <= 1'b0;
								end
								smts_pkg::CMD_ONESHOT:  mode_q[slot] <= 1'b0;
								smts_pkg::CMD_PERIODIC: mode_q[slot] <= 1'b1;
								default: ;
							endcase
						end
					end
				end
				smts_pkg::S_INS: begin
					run_q[sid_q] <= 1'b1;
					if (tick_q) rr_q <= rr_q + 1'b1;
				end
				smts_pkg::S_DRAIN: begin
					if (due) begin
						if (!pend_v_q || out_free) begin
							pend_v_q        <= 1'b1;
							fire_n_q        <= fire_n_q + 1'b1;
							run_q[head_id]  <= 1'b0;
							if (mode_q[head_id]) nre_q <= nre_q + 1'b1;
							else alloc_q[head_id] <= 1'b0;
						end
					end else if (out_free) begin
						pend_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			smts_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd.command;
					tid_q <= cmd.timer_id;
					val_q <= cmd.value;
					per_q <= cmd.periodic;
				end
			end
			smts_pkg::S_EXEC: begin
				sid_q   <= slot;
				rkind_q <= smts_pkg::KIND_ACK;
				rval_q  <= '0;
				if (cmd_q > smts_pkg::CMD_READ) begin
					rkind_q <= smts_pkg::KIND_ACK;
				end else if (!id_ok) begin
					rkind_q <= smts_pkg::KIND_ERROR;
				end else if (cmd_q == smts_pkg::CMD_CREATE) begin
					if (!(alloc_q[slot] && run_q[slot])) period_q[slot] <= val_q;
				end else if (!alloc_q[slot]) begin
					rkind_q <= smts_pkg::KIND_ERROR;
				end else if (cmd_q == smts_pkg::CMD_SET_INTV) begin
					period_q[slot] <= val_q;
				end else if (cmd_q == smts_pkg::CMD_READ) begin
					rkind_q <= smts_pkg::KIND_READ;
					rval_q  <= period_q[slot];
				end
			end
			smts_pkg::S_CALC: begin
				sid_q <= calc_sid;
				dl_q  <= now_q + TICK_BITS'(period_q[calc_sid]);
			end
			smts_pkg::S_RESP: begin
				if (out_free) begin
					out_kind_q <= rkind_q;
					out_id_q   <= tid_q;
					out_rv_q   <= rval_q;
					out_last_q <= 1'b1;
				end
			end
			smts_pkg::S_DRAIN: begin
				if (due) begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_kind_q <= smts_pkg::KIND_FIRED;
							out_id_q   <= 4'(pend_id_q);
							out_rv_q   <= '0;
							out_last_q <= 1'b0;
						end
						pend_id_q <= head_id;
						if (mode_q[head_id]) rearm_q[nre_q[RA_W-1:0]] <= head_id;
					end
				end else if (out_free) begin
					out_kind_q <= pend_v_q ? smts_pkg::KIND_FIRED : smts_pkg::KIND_ACK;
					out_id_q   <= pend_v_q ? 4'(pend_id_q) : 4'd0;
					out_rv_q   <= '0;
					out_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/smts_cell.sv]
// One cell of the sorted timer queue: holds one (slot, deadline) entry.
// Depends on smts_pkg.
module smts_cell #(
	parameter int unsigned SLOT_W    = 4,
	parameter int unsigned TICK_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smts_pkg::q_op_t      op,
	input  logic [SLOT_W-1:0]    op_id,
	input  logic [TICK_BITS-1:0] op_dl,
	// left neighbor
	input  logic                 left_valid,
	input  logic [SLOT_W-1:0]    left_id,
	input  logic [TICK_BITS-1:0] left_dl,
	// right neighbor
	input  logic                 right_valid,
	input  logic [SLOT_W-1:0]    right_id,
	input  logic [TICK_BITS-1:0] right_dl,
	// prefix chains
	input  logic                 ins_run_in,
	output logic                 ins_run_out,
	input  logic                 rm_hit_in,
	output logic                 rm_hit_out,
	// own entry
	output logic                 valid,
	output logic [SLOT_W-1:0]    id,
	output logic [TICK_BITS-1:0] dl
);

	logic                 valid_q;
	logic [SLOT_W-1:0]    id_q;
	logic [TICK_BITS-1:0] dl_q;
	logic [TICK_BITS-1:0] diff;
	logic                 new_not_after;
	logic                 go;

	// new entry goes past this one unless its deadline is not after ours
	assign diff          = op_dl - dl_q;
	assign new_not_after = (diff == '0) || diff[TICK_BITS-1];
	assign go            = valid_q && !new_not_after;
	assign ins_run_out   = ins_run_in && go;
	assign rm_hit_out    = rm_hit_in || (valid_q && id_q == op_id);

	assign valid = valid_q;
	assign id    = id_q;
	assign dl    = dl_q;

	// entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				smts_pkg::Q_INSERT: begin
					if (ins_run_in && !go) valid_q <= 1'b1;
					else if (!ins_run_in) valid_q <= left_valid;
				end
				smts_pkg::Q_REMOVE: begin
					if (rm_hit_out) valid_q <= right_valid;
				end
				default: ;
			endcase
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		case (op)
			smts_pkg::Q_INSERT: begin
				if (ins_run_in && !go) begin
					id_q <= op_id;
					dl_q <= op_dl;
				end else if (!ins_run_in) begin
					id_q <= left_id;
					dl_q <= left_dl;
				end
			end
			smts_pkg::Q_REMOVE: begin
				if (rm_hit_out) begin
					id_q <= right_id;
					dl_q <= right_dl;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/smts_queue.sv]
// Sorted timer queue built as a row of smts_cell; head at cell 0.
// Depends on smts_pkg and smts_cell.
module smts_queue #(
	parameter int unsigned NUM_CELLS = 16,
	parameter int unsigned SLOT_W    = 4,
	parameter int unsigned TICK_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smts_pkg::q_op_t      op,
	input  logic [SLOT_W-1:0]    op_id,
	input  logic [TICK_BITS-1:0] op_dl,
	output logic                 head_valid,
	output logic [SLOT_W-1:0]    head_id,
	output logic [TICK_BITS-1:0] head_dl
);

	logic                 c_valid [NUM_CELLS];
	logic [SLOT_W-1:0]    c_id    [NUM_CELLS];
	logic [TICK_BITS-1:0] c_dl    [NUM_CELLS];
	logic                 ins_run [NUM_CELLS+1];
	logic                 rm_hit  [NUM_CELLS+1];

	assign ins_run[0] = 1'b1;
	assign rm_hit[0]  = 1'b0;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		logic                 lv, rv;
		logic [SLOT_W-1:0]    lid, rid;
		logic [TICK_BITS-1:0] ldl, rdl;

		if (i == 0) begin : g_first
			assign lv  = 1'b0;
			assign lid = '0;
			assign ldl = '0;
		end else begin : g_mid
			assign lv  = c_valid[i-1];
			assign lid = c_id[i-1];
			assign ldl = c_dl[i-1];
		end

		if (i == NUM_CELLS - 1) begin : g_last
			assign rv  = 1'b0;
			assign rid = '0;
			assign rdl = '0;
		end else begin : g_inner
			assign rv  = c_valid[i+1];
			assign rid = c_id[i+1];
			assign rdl = c_dl[i+1];
		end

		smts_cell #(
			.SLOT_W    (SLOT_W),
			.TICK_BITS (TICK_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.op_id       (op_id),
			.op_dl       (op_dl),
			.left_valid  (lv),
			.left_id     (lid),
			.left_dl     (ldl),
			.right_valid (rv),
			.right_id    (rid),
			.right_dl    (rdl),
			.ins_run_in  (ins_run[i]),
			.ins_run_out (ins_run[i+1]),
			.rm_hit_in   (rm_hit[i]),
			.rm_hit_out  (rm_hit[i+1]),
			.valid       (c_valid[i]),
			.id          (c_id[i]),
			.dl          (c_dl[i])
		);
	end

	assign head_valid = c_valid[0];
	assign head_id    = c_id[0];
	assign head_dl    = c_dl[0];

endmodule

[tb/sv/timer_result_monitor.sv]
`timescale 1ns / 100ps
// Watches the command and result channels of the timer scheduler, predicts the results of every
// accepted command and compares them field by field. Depends on smts_pkg and smts_if.
module timer_result_monitor (
	input  logic        clk,
	input  logic        arst_n,
	smts_cmd_if         cmd,
	smts_res_if         res,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  id;
		logic [31:0] rv;
		logic        last;
	} timer_result_t;

	localparam int unsigned SLOTS = 16;

	// Predicted scheduler state
	logic [31:0]    now_ticks;
	logic [31:0]    due_at   [SLOTS];
	logic [31:0]    interval [SLOTS];
	logic           repeats  [SLOTS];
	logic           in_use   [SLOTS];
	logic           armed    [SLOTS];
	int unsigned    deadline_order[$];
	timer_result_t  expected_results[$];

	assign pending = expected_results.size();

	// a is due no later than b under wrapping comparison
	function automatic bit due_first(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d == 32'd0 || d[31];
	endfunction

	function automatic void add_result(logic [1:0] kind, logic [3:0] id, logic [31:0] rv);
		timer_result_t r;
		r.kind = kind;
		r.id   = id;
		r.rv   = rv;
		r.last = 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic void unlink(int unsigned slot);
		for (int i = 0; i < deadline_order.size(); i++) begin
			if (deadline_order[i] == slot) begin
				deadline_order.delete(i);
				return;
			end
		end
	endfunction

	// Newest timer goes ahead of any equal deadline
	function automatic void link(int unsigned slot);
		int pos;
		pos = 0;
		while (pos < deadline_order.size() && !due_first(due_at[slot], due_at[deadline_order[pos]]))
			pos++;
		deadline_order.insert(pos, slot);
	endfunction

	function automatic void halt(int unsigned slot);
		if (armed[slot]) unlink(slot);
		armed[slot] = 1'b0;
	endfunction

	function automatic void arm(int unsigned slot);
		halt(slot);
		due_at[slot] = now_ticks + interval[slot];
		link(slot);
		armed[slot] = 1'b1;
	endfunction

	function automatic void predict_command(logic [3:0] op, logic [3:0] id, logic [31:0] val,
			logic per);
		int unsigned fired;
		int unsigned s;
		int unsigned rearm[$];
		fired = 0;
		if (op == smts_pkg::CMD_TICK) begin
			now_ticks = now_ticks + 32'd1;
			while (deadline_order.size() > 0 && fired < smts_pkg::MAX_FIRE &&
					due_first(due_at[deadline_order[0]], now_ticks)) begin
				s = deadline_order[0];
				deadline_order.delete(0);
				armed[s] = 1'b0;
				add_result(smts_pkg::KIND_FIRED, s[3:0], 32'd0);
				fired++;
				if (repeats[s]) rearm.push_back(s);
				else in_use[s] = 1'b0;
			end
			// periodic timers go back in after the drain, in firing order
			foreach (rearm[i]) begin
				due_at[rearm[i]] = now_ticks + interval[rearm[i]];
				link(rearm[i]);
				armed[rearm[i]] = 1'b1;
			end
			if (fired == 0) add_result(smts_pkg::KIND_ACK, 4'd0, 32'd0);
		end else if (op > smts_pkg::CMD_READ) begin
			add_result(smts_pkg::KIND_ACK, id, 32'd0);
		end else if (op == smts_pkg::CMD_CREATE) begin
			if (in_use[id] && armed[id]) begin
				halt(id);
			end else begin
				in_use[id]   = 1'b1;
				armed[id]    = 1'b0;
				interval[id] = val;
				repeats[id]  = per;
			end
			add_result(smts_pkg::KIND_ACK, id, 32'd0);
		end else if (!in_use[id]) begin
			add_result(smts_pkg::KIND_ERROR, id, 32'd0);
		end else begin
			case (op)
				smts_pkg::CMD_START: arm(id);
				smts_pkg::CMD_STOP: halt(id);
				smts_pkg::CMD_DELETE: begin
					halt(id);
					in_use[id] = 1'b0;
				end
				smts_pkg::CMD_SET_INTV: begin
					halt(id);
					interval[id] = val;
					arm(id);
				end
				smts_pkg::CMD_ONESHOT: repeats[id] = 1'b0;
				smts_pkg::CMD_PERIODIC: begin
					halt(id);
					repeats[id] = 1'b1;
					arm(id);
				end
				default: ;
			endcase
			if (op == smts_pkg::CMD_READ) add_result(smts_pkg::KIND_READ, id, interval[id]);
			else add_result(smts_pkg::KIND_ACK, id, 32'd0);
		end
		expected_results[expected_results.size() - 1].last = 1'b1;
	endfunction

	// Compare accepted results, then predict from accepted commands
	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		if (!arst_n) begin
			now_ticks  = '0;
			fail_count = 0;
			for (int i = 0; i < SLOTS; i++) begin
				repeats[i] = 1'b0;
				in_use[i]  = 1'b0;
				armed[i]   = 1'b0;
			end
			deadline_order.delete();
			expected_results.delete();
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d id=%0d value=%h last=%0d", $time,
						res.kind, res.fired_id, res.read_value, res.last);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.kind !== res.kind || want.id !== res.fired_id ||
							want.rv !== res.read_value || want.last !== res.last) begin
						$display("%0t: mismatch expected kind=%0d id=%0d value=%h last=%0d",
							$time, want.kind, want.id, want.rv, want.last);
						$display("%0t:          actual   kind=%0d id=%0d value=%h last=%0d",
							$time, res.kind, res.fired_id, res.read_value, res.last);
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				predict_command(cmd.command, cmd.timer_id, cmd.value, cmd.periodic);
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the timer scheduler testbench: clock, reset, command stimulus, result stalls and
// verdict. Depends on smts_pkg, smts_if, the scheduler and timer_result_monitor.
module testbench;

	localparam int unsigned CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	bit          send_gaps;
	bit          recv_stalls;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count;

	smts_cmd_if cmd_ch ();
	smts_res_if res_ch ();

	sorted_multi_timer_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	timer_result_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random stall before each item while recv_stalls is set
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_stalls ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// Drive one command item and wait for it to be taken
	task automatic issue(logic [3:0] op, logic [3:0] id, logic [31:0] val, logic per);
		int gap;
		gap = send_gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.command  <= op;
		cmd_ch.timer_id <= id;
		cmd_ch.value    <= val;
		cmd_ch.periodic <= per;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Mostly short intervals so timers fire; sometimes wide or near the wrap point
	function automatic logic [31:0] pick_interval();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return $urandom_range(0, 6);
		if (r < 85) return $urandom_range(0, 40);
		if (r < 93) return $urandom();
		return 32'h8000_0000 + $urandom_range(0, 2) - 32'd1;
	endfunction

	function automatic logic [3:0] pick_command();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) return smts_pkg::CMD_TICK;
		if (r < 48) return smts_pkg::CMD_CREATE;
		if (r < 63) return smts_pkg::CMD_START;
		if (r < 69) return smts_pkg::CMD_STOP;
		if (r < 74) return smts_pkg::CMD_DELETE;
		if (r < 82) return smts_pkg::CMD_SET_INTV;
		if (r < 86) return smts_pkg::CMD_ONESHOT;
		if (r < 92) return smts_pkg::CMD_PERIODIC;
		if (r < 98) return smts_pkg::CMD_READ;
		return 4'($urandom_range(9, 15));
	endfunction

	initial begin
		cmd_ch.valid    <= 1'b0;
		cmd_ch.command  <= smts_pkg::CMD_TICK;
		cmd_ch.timer_id <= 4'd0;
		cmd_ch.value    <= 32'd0;
		cmd_ch.periodic <= 1'b0;
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: errors on free slots, unused codes, ties, restarts, wrap, zero period
		issue(smts_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
		issue(smts_pkg::CMD_START, 4'd3, 32'd0, 1'b0);
		issue(smts_pkg::CMD_READ, 4'd15, 32'd0, 1'b0);
		issue(4'd9, 4'd5, 32'd0, 1'b0);
		issue(4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1);
		issue(smts_pkg::CMD_CREATE, 4'd0, 32'd0, 1'b1);
		issue(smts_pkg::CMD_CREATE, 4'd15, 32'hFFFF_FFFF, 1'b0);
		issue(smts_pkg::CMD_CREATE, 4'd1, 32'd2, 1'b0);
		issue(smts_pkg::CMD_CREATE, 4'd2, 32'd2, 1'b1);
		issue(smts_pkg::CMD_START, 4'd0, 32'd0, 1'b0);
		issue(smts_pkg::CMD_START, 4'd1, 32'd0, 1'b0);
		issue(smts_pkg::CMD_START, 4'd2, 32'd0, 1'b0);
		issue(smts_pkg::CMD_START, 4'd15, 32'd0, 1'b0);
		issue(smts_pkg::CMD_START, 4'd2, 32'd0, 1'b0);
		issue(smts_pkg::CMD_CREATE, 4'd15, 32'd7, 1'b1);
		issue(smts_pkg::CMD_READ, 4'd15, 32'd0, 1'b0);
		issue(smts_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
		issue(smts_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
		issue(smts_pkg::CMD_SET_INTV, 4'd15, 32'h8000_0000, 1'b0);
		issue(smts_pkg::CMD_PERIODIC, 4'd2, 32'd0, 1'b0);
		issue(smts_pkg::CMD_ONESHOT, 4'd0, 32'd0, 1'b0);
		issue(smts_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
		issue(smts_pkg::CMD_STOP, 4'd2, 32'd0, 1'b0);
		issue(smts_pkg::CMD_DELETE, 4'd15, 32'd0, 1'b0);
		issue(smts_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);

		// Random phases with every combination of idling on the two sides
		for (int phase = 0; phase < 4; phase++) begin
			send_gaps   = phase[0];
			recv_stalls = phase[1];
			for (int n = 0; n < 88; n++)
				issue(pick_command(), 4'($urandom_range(0, 15)), pick_interval(),
					1'($urandom_range(0, 1)));
		end
		cmd_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/smts_pkg.sv
rtl/core/smts_if.sv
rtl/core/smts_cell.sv
rtl/core/smts_queue.sv
rtl/core/sorted_multi_timer_scheduler.sv
tb/sv/timer_result_monitor.sv
tb/sv/testbench.sv
